// ===== sv/fta_pkg.sv =====
// Shared types and defaults for the frame table allocator.
package fta_pkg;

	localparam int FRAMES_DEF   = 64;
	localparam int AGE_BITS_DEF = 16;
	localparam int IDX_OUT_BITS = 6;

	typedef enum logic [1:0] {
		OP_MARK_USED = 2'd0,
		OP_MARK_FREE = 2'd1,
		OP_TOUCH     = 2'd2,
		OP_QUERY     = 2'd3
	} op_t;

	typedef struct packed {
		op_t                     operation;
		logic [IDX_OUT_BITS-1:0] frame_index;
	} req_t;

	typedef struct packed {
		logic                    free_found;
		logic [IDX_OUT_BITS-1:0] first_free;
		logic [IDX_OUT_BITS-1:0] victim;
	} rsp_t;

	// Update broadcast to every cell in the accept cycle.
	typedef struct packed {
		logic                    mark_used;
		logic                    mark_free;
		logic                    touch;
		logic [IDX_OUT_BITS-1:0] frame;
	} upd_t;

endpackage

// ===== sv/frame_table_alloc_lru_unit.sv =====
// Top level of the frame table allocator with LRU aging.
//
// Keeps a used bit and a saturating age for each of FRAMES frames. Issue a
// request by raising start while busy is low; the request is taken at that
// edge and busy rises. Each request produces exactly one response, shown on
// rsp for one cycle with strobe high; the receiver cannot stall it, so
// capture it then. Between accept and the next possible accept, the update
// is applied to every frame cell, a search record is injected and walks the
// chain of FRAMES cells one frame per cycle, and the response is registered.
// A request can be issued in the cycle that strobe is high.
// Frame indices at or beyond FRAMES leave the table untouched. The response
// reports free_found, the lowest free frame (zero when none is free), and the
// oldest frame as victim with the lowest index winning ties; indices are
// given in their low six bits. Reset clears all used bits and ages at once.
module frame_table_alloc_lru_unit #(
	parameter int FRAMES   = fta_pkg::FRAMES_DEF,
	parameter int AGE_BITS = fta_pkg::AGE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  fta_pkg::req_t req,
	output logic          strobe,
	output fta_pkg::rsp_t rsp
);

	localparam int IDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int OB       = fta_pkg::IDX_OUT_BITS;

	logic          accept;
	logic          in_range;
	fta_pkg::upd_t upd;
	logic          busy_q;
	logic          go_q;
	logic          strobe_q;
	fta_pkg::rsp_t rsp_q;

	// Search chain links, one more than the number of cells.
	logic                valid_c    [FRAMES+1];
	logic                found_c    [FRAMES+1];
	logic [IDX_BITS-1:0] first_c    [FRAMES+1];
	logic [AGE_BITS-1:0] best_age_c [FRAMES+1];
	logic [IDX_BITS-1:0] best_idx_c [FRAMES+1];

	logic [IDX_BITS+OB-1:0] first_ext;
	logic [IDX_BITS+OB-1:0] victim_ext;

	assign accept   = start && !busy_q;
	assign in_range = (32'(req.frame_index) < 32'(FRAMES));

	// Broadcast the update only in the accept cycle and only for a real frame.
	always_comb begin
		upd.mark_used = accept && in_range && (req.operation == fta_pkg::OP_MARK_USED);
		upd.mark_free = accept && in_range && (req.operation == fta_pkg::OP_MARK_FREE);
		upd.touch     = accept && in_range && (req.operation == fta_pkg::OP_TOUCH);
		upd.frame     = req.frame_index;
	end

	// Inject a fresh search record into the head of the chain after the update.
	assign valid_c[0]    = go_q;
	assign found_c[0]    = 1'b0;
	assign first_c[0]    = '0;
	assign best_age_c[0] = '0;
	assign best_idx_c[0] = '0;

	for (genvar g = 0; g < FRAMES; g++) begin : g_cell
		fta_cell #(
			.CELL_IDX (g),
			.IDX_BITS (IDX_BITS),
			.AGE_BITS (AGE_BITS)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.upd          (upd),
			.valid_in     (valid_c[g]),
			.found_in     (found_c[g]),
			.first_in     (first_c[g]),
			.best_age_in  (best_age_c[g]),
			.best_idx_in  (best_idx_c[g]),
			.valid_out    (valid_c[g+1]),
			.found_out    (found_c[g+1]),
			.first_out    (first_c[g+1]),
			.best_age_out (best_age_c[g+1]),
			.best_idx_out (best_idx_c[g+1])
		);
	end

	// Report indices in their low six bits, zero-extended for small tables.
	assign first_ext  = {{OB{1'b0}}, first_c[FRAMES]};
	assign victim_ext = {{OB{1'b0}}, best_idx_c[FRAMES]};

	// Sequence control: hold busy from accept until the record leaves the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			go_q     <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			go_q     <= accept;
			strobe_q <= valid_c[FRAMES];
			if (accept) begin
				busy_q <= 1'b1;
			end else if (valid_c[FRAMES]) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Response register: capture the finished record for one strobe cycle.
	always_ff @(posedge clk) begin
		if (valid_c[FRAMES]) begin
			rsp_q.free_found <= found_c[FRAMES];
			rsp_q.first_free <= found_c[FRAMES] ? first_ext[OB-1:0] : '0;
			rsp_q.victim     <= victim_ext[OB-1:0];
		end
	end

	assign busy   = busy_q;
	assign strobe = strobe_q;
	assign rsp    = rsp_q;

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after accept");

	a_busy_drop_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe)
		else $error("busy dropped without a result");

	a_result_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("result strobe lasted more than one cycle");

	a_result_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("result shown while still busy");

	a_none_free_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !rsp.free_found) |-> (rsp.first_free == '0))
		else $error("first_free nonzero with no free frame");
`endif

endmodule

// ===== sv/fta_cell.sv =====
// One frame cell: used bit, age, and one stage of the search chain.
module fta_cell #(
	parameter int CELL_IDX = 0,
	parameter int IDX_BITS = 6,
	parameter int AGE_BITS = fta_pkg::AGE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fta_pkg::upd_t       upd,
	input  logic                valid_in,
	input  logic                found_in,
	input  logic [IDX_BITS-1:0] first_in,
	input  logic [AGE_BITS-1:0] best_age_in,
	input  logic [IDX_BITS-1:0] best_idx_in,
	output logic                valid_out,
	output logic                found_out,
	output logic [IDX_BITS-1:0] first_out,
	output logic [AGE_BITS-1:0] best_age_out,
	output logic [IDX_BITS-1:0] best_idx_out
);

	localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

	logic                used_q;
	logic [AGE_BITS-1:0] age_q;
	logic                hit;
	logic                valid_q;
	logic                found_q;
	logic [IDX_BITS-1:0] first_q;
	logic [AGE_BITS-1:0] best_age_q;
	logic [IDX_BITS-1:0] best_idx_q;

	assign hit = (32'(upd.frame) == 32'(CELL_IDX));

	// Frame state: mark, free, or on a touch clear this frame's age if it is the one touched, else age it, saturating.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			age_q  <= '0;
		end else begin
			if (hit && upd.mark_used) begin
				used_q <= 1'b1;
			end
			if (hit && upd.mark_free) begin
				used_q <= 1'b0;
			end
			if (upd.touch) begin
				if (hit) begin
					age_q <= '0;
				end else if (age_q != '1) begin
					age_q <= age_q + AGE_BITS'(1);
				end
			end
		end
	end

	// Search stage: merge this frame into the record passing by.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		found_q    <= found_in | ~used_q;
		first_q    <= found_in ? first_in : MY_IDX;
		best_age_q <= (age_q > best_age_in) ? age_q : best_age_in;
		best_idx_q <= (age_q > best_age_in) ? MY_IDX : best_idx_in;
	end

	assign valid_out    = valid_q;
	assign found_out    = found_q;
	assign first_out    = first_q;
	assign best_age_out = best_age_q;
	assign best_idx_out = best_idx_q;

endmodule

// ===== tb/testbench.sv =====
// Self-checking regression for the frame table allocator with LRU aging.
`timescale 1ns / 100ps

module testbench;
	import fta_pkg::*;

	localparam int FRAMES       = FRAMES_DEF;
	localparam int AGE_BITS     = AGE_BITS_DEF;
	localparam int RANDOM_ITEMS = 1800;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int MAX_GAP      = 70;

	typedef logic [IDX_OUT_BITS-1:0] frame_t;

	// One row of the directed table: the request, and where the answer is
	// obvious, the response typed in by hand.
	typedef struct packed {
		op_t    op;
		frame_t idx;
		logic   typed;
		rsp_t   want;
	} row_t;

	localparam int DIR_ROWS = 22;
	localparam row_t DIRECTED [DIR_ROWS] = '{
		// fresh out of reset: everything free, all ages equal
		'{OP_QUERY,     6'd0,  1'b1, '{1'b1, 6'd0, 6'd0}},
		// query ignores the frame index
		'{OP_QUERY,     6'd63, 1'b1, '{1'b1, 6'd0, 6'd0}},
		'{OP_MARK_USED, 6'd0,  1'b1, '{1'b1, 6'd1, 6'd0}},
		// marking an already used frame changes nothing
		'{OP_MARK_USED, 6'd0,  1'b1, '{1'b1, 6'd1, 6'd0}},
		'{OP_MARK_USED, 6'd1,  1'b1, '{1'b1, 6'd2, 6'd0}},
		'{OP_MARK_FREE, 6'd0,  1'b1, '{1'b1, 6'd0, 6'd0}},
		// freeing an already free frame changes nothing
		'{OP_MARK_FREE, 6'd0,  1'b1, '{1'b1, 6'd0, 6'd0}},
		// first touch: frame 0 youngest, frames 1..63 tie, lowest wins
		'{OP_TOUCH,     6'd0,  1'b1, '{1'b1, 6'd0, 6'd1}},
		'{OP_TOUCH,     6'd63, 1'b1, '{1'b1, 6'd0, 6'd1}},
		'{OP_TOUCH,     6'd1,  1'b0, '0},
		'{OP_MARK_USED, 6'd63, 1'b0, '0},
		'{OP_MARK_USED, 6'd42, 1'b0, '0},
		'{OP_MARK_USED, 6'd21, 1'b0, '0},
		'{OP_TOUCH,     6'd42, 1'b0, '0},
		'{OP_TOUCH,     6'd21, 1'b0, '0},
		'{OP_MARK_FREE, 6'd1,  1'b0, '0},
		'{OP_MARK_USED, 6'd0,  1'b0, '0},
		'{OP_MARK_FREE, 6'd63, 1'b0, '0},
		'{OP_QUERY,     6'd42, 1'b0, '0},
		'{OP_TOUCH,     6'd2,  1'b0, '0},
		'{OP_MARK_FREE, 6'd21, 1'b0, '0},
		'{OP_QUERY,     6'd21, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic strobe;
	rsp_t rsp;

	// Typed answer travels with the request so the monitor can pick it up
	// at the accepting edge.
	logic hold_typed = 1'b0;
	rsp_t hold_rsp = '0;

	// Local copy of the frame table state.
	logic                used_map [FRAMES];
	logic [AGE_BITS-1:0] age_tab  [FRAMES];

	rsp_t   pending_rsp [$];
	int     err_count = 0;
	int     sent_count = 0;
	int     cycle_count = 0;
	bit     idle_on = 1'b1;

	frame_table_alloc_lru_unit #(
		.FRAMES  (FRAMES),
		.AGE_BITS(AGE_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.strobe(strobe),
		.rsp   (rsp)
	);

	always #6 clk = ~clk;

	// Apply one request to the local table and return the response it
	// should produce: update first, then scan for lowest free and oldest.
	function automatic rsp_t frame_table_step(op_t op, frame_t idx);
		rsp_t res;
		int   oldest;
		bit   found;
		res = '0;
		oldest = 0;
		found = 1'b0;
		if (op != OP_QUERY && int'(idx) < FRAMES) begin
			case (op)
				OP_MARK_USED: used_map[idx] = 1'b1;
				OP_MARK_FREE: used_map[idx] = 1'b0;
				default: begin
					// age everything, saturating, then make the touched frame youngest
					for (int i = 0; i < FRAMES; i++)
						if (age_tab[i] != '1)
							age_tab[i] = age_tab[i] + 1'b1;
					age_tab[idx] = '0;
				end
			endcase
		end
		for (int i = 0; i < FRAMES; i++) begin
			if (!found && !used_map[i]) begin
				found = 1'b1;
				res.first_free = frame_t'(i);
			end
			if (age_tab[i] > age_tab[oldest])
				oldest = i;
		end
		res.free_found = found;
		res.victim = frame_t'(oldest);
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("cycle %0d: %s", cycle_count, msg);
		err_count++;
	endtask

	// Drive one transaction and hold it until the block takes it. Now and then
	// insert a random gap first so start rises at every phase of the busy window.
	task automatic issue_request(input op_t op, input frame_t idx, input logic typed,
			input rsp_t want);
		if (idle_on && $urandom_range(99) < 12) begin
			start <= 1'b0;
			repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
		end
		start <= 1'b1;
		req <= '{operation: op, frame_index: idx};
		hold_typed <= typed;
		hold_rsp <= want;
		do @(posedge clk); while (busy);
		sent_count++;
	endtask

	task automatic random_request(input op_t op, input frame_t idx);
		idle_on = !(sent_count >= 600 && sent_count < 1000);
		issue_request(op, idx, 1'b0, '0);
	endtask

	// Monitor: check the response in its strobe cycle, then record the
	// expectation for a transaction accepted at this same edge.
	always @(posedge clk) begin
		rsp_t want;
		rsp_t model_rsp;
		if (arst_n) begin
			if (strobe) begin
				if (pending_rsp.size() == 0) begin
					report_mismatch($sformatf("response %p with nothing outstanding", rsp));
				end else begin
					want = pending_rsp.pop_front();
					if (rsp.free_found !== want.free_found)
						report_mismatch($sformatf("free_found got %b, expected %b",
							rsp.free_found, want.free_found));
					if (rsp.first_free !== want.first_free)
						report_mismatch($sformatf("first_free got %0d, expected %0d",
							rsp.first_free, want.first_free));
					if (rsp.victim !== want.victim)
						report_mismatch($sformatf("victim got %0d, expected %0d",
							rsp.victim, want.victim));
				end
			end
			if (start && !busy) begin
				model_rsp = frame_table_step(req.operation, req.frame_index);
				pending_rsp.push_back(hold_typed ? hold_rsp : model_rsp);
			end
		end
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("frame_table_alloc_lru_unit regression: fail");
			$finish;
		end
	end

	initial begin
		int     burst;
		int     lo;
		int     hi;
		int     span;
		frame_t base;
		bit     down;

		for (int i = 0; i < FRAMES; i++) begin
			used_map[i] = 1'b0;
			age_tab[i] = '0;
		end

		// Hold reset, then release it on a clock edge.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed table.
		for (int r = 0; r < DIR_ROWS; r++)
			issue_request(DIRECTED[r].op, DIRECTED[r].idx, DIRECTED[r].typed,
				DIRECTED[r].want);

		// Random bursts: noise, full sweeps that exhaust the table, partial
		// frees, and touch storms over a narrow window to spread the ages.
		while (sent_count < DIR_ROWS + RANDOM_ITEMS) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					burst = $urandom_range(5, 25);
					repeat (burst)
						random_request(op_t'($urandom_range(3)), frame_t'($urandom_range(63)));
				end
				3: begin
					// fill every frame, then confirm nothing is left free
					down = $urandom_range(1);
					for (int i = 0; i < FRAMES; i++)
						random_request(OP_MARK_USED, frame_t'(down ? FRAMES - 1 - i : i));
					random_request(OP_QUERY, frame_t'($urandom_range(63)));
				end
				4, 5: begin
					base = frame_t'($urandom_range(63));
					span = $urandom_range(1, 8);
					burst = $urandom_range(5, 30);
					repeat (burst)
						random_request(OP_TOUCH, base + frame_t'($urandom_range(span - 1)));
					random_request(OP_QUERY, frame_t'($urandom_range(63)));
				end
				6: begin
					lo = $urandom_range(63);
					hi = $urandom_range(lo, 63);
					for (int i = lo; i <= hi; i++)
						random_request(OP_MARK_FREE, frame_t'(i));
				end
				7: begin
					burst = $urandom_range(1, 4);
					repeat (burst)
						random_request(OP_MARK_FREE, frame_t'($urandom_range(63)));
					random_request(OP_QUERY, frame_t'($urandom_range(63)));
				end
				default: begin
					burst = $urandom_range(5, 20);
					repeat (burst)
						random_request($urandom_range(1) ? OP_MARK_USED : OP_TOUCH,
							frame_t'($urandom_range(63)));
				end
			endcase
		end

		// Drop start, drain outstanding responses, then watch for strays.
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (FRAMES + 8) @(posedge clk);

		if (err_count == 0)
			$display("frame_table_alloc_lru_unit regression: pass");
		else
			$display("frame_table_alloc_lru_unit regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/fta_pkg.sv
sv/fta_cell.sv
sv/frame_table_alloc_lru_unit.sv
tb/testbench.sv
